@@ sv/qpmm_pkg.sv @@
// shared constants and types for the plus-frame quadrotor motor mixer
package qpmm_pkg;

    localparam int DATA_WIDTH_DEF    = 16;
    localparam int TORQUE_GAIN_W     = 16;
    localparam int SPEED_GAIN_W      = 24;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 24;
    localparam int QUEUE_DEPTH       = 4;
    localparam int ROTORS            = 4;
    localparam int THRUST_SHIFT      = 10;
    localparam int RAD_SHIFT         = 12;
    localparam int ROUND_SHIFT       = 20;

    localparam logic [TORQUE_GAIN_W-1:0] TORQUE_GAIN_RESET = 16'd12047;
    localparam logic [SPEED_GAIN_W-1:0]  SPEED_GAIN_RESET  = 24'd87557;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_TORQUE_GAIN = 2'd0;
    localparam t_cfg_index CFG_SPEED_GAIN  = 2'd1;

    // rotor lanes in result order
    localparam int LANE_FRONT = 0;
    localparam int LANE_LEFT  = 1;
    localparam int LANE_BACK  = 2;
    localparam int LANE_RIGHT = 3;

endpackage

@@ sv/qpmm_front.sv @@
// front end: takes commands, forms the four rotor thrusts and flags negative ones
module qpmm_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [DATA_WIDTH-1:0]                 i_total_thrust,
    input  logic signed [DATA_WIDTH-1:0]          i_roll_torque,
    input  logic signed [DATA_WIDTH-1:0]          i_pitch_torque,
    input  logic [qpmm_pkg::TORQUE_GAIN_W-1:0]    i_torque_gain,
    input  logic [$clog2(qpmm_pkg::QUEUE_DEPTH+1)-1:0] i_queue_count,
    output logic                                  o_push,
    output logic [qpmm_pkg::ROTORS-1:0][DATA_WIDTH+15:0] o_thrust,
    output logic                                  o_low
);
    import qpmm_pkg::*;

    localparam int FW = DATA_WIDTH + 16;
    localparam int SW = FW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                  r_vld;
    logic [DATA_WIDTH-1:0] r_thrust;
    logic signed [FW-1:0]  r_roll;
    logic signed [FW-1:0]  r_pitch;

    logic                  accept;
    logic [CW+1:0]         occupancy;
    logic signed [FW:0]    roll_prod;
    logic signed [FW:0]    pitch_prod;
    logic signed [SW-1:0]  q_ext;
    logic signed [SW-1:0]  roll_ext;
    logic signed [SW-1:0]  pitch_ext;
    logic [ROTORS-1:0][SW-1:0] sums;
    logic [ROTORS-1:0]     neg;

    // credit: items in flight plus queued must fit the queue
    assign occupancy = (CW+2)'(i_queue_count) + (CW+2)'(r_vld);
    assign o_stall   = occupancy >= (CW+2)'(QUEUE_DEPTH);
    assign accept    = i_valid && !o_stall;

    assign roll_prod  = i_roll_torque * $signed({1'b0, i_torque_gain});
    assign pitch_prod = i_pitch_torque * $signed({1'b0, i_torque_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_thrust <= i_total_thrust;
            r_roll   <= roll_prod[FW-1:0];
            r_pitch  <= pitch_prod[FW-1:0];
        end
    end

    assign q_ext     = $signed(SW'({r_thrust, {THRUST_SHIFT{1'b0}}}));
    assign roll_ext  = $signed({r_roll[FW-1], r_roll});
    assign pitch_ext = $signed({r_pitch[FW-1], r_pitch});

    assign sums[LANE_FRONT] = q_ext - pitch_ext;
    assign sums[LANE_LEFT]  = q_ext + roll_ext;
    assign sums[LANE_BACK]  = q_ext + pitch_ext;
    assign sums[LANE_RIGHT] = q_ext - roll_ext;

    always_comb begin
        for (int l = 0; l < ROTORS; l++) begin
            neg[l] = sums[l][SW-1];
            o_thrust[l] = neg[l] ? '0 : sums[l][FW-1:0];
        end
    end

    assign o_push = r_vld;
    assign o_low  = |neg;

endmodule

@@ sv/qpmm_queue.sv @@
// short fifo between the front end and the square root pipeline
module qpmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import qpmm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

@@ sv/qpmm_back.sv @@
// back end: pipelined square root, speed gain, rounding and saturation
module qpmm_back #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [qpmm_pkg::ROTORS-1:0][DATA_WIDTH+15:0]  i_thrust,
    input  logic                                          i_low,
    input  logic [qpmm_pkg::SPEED_GAIN_W-1:0]             i_speed_gain,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic [qpmm_pkg::ROTORS-1:0][DATA_WIDTH-1:0]   o_speed,
    output logic                                          o_low,
    output logic                                          o_high
);
    import qpmm_pkg::*;

    localparam int FW = DATA_WIDTH + 16;
    localparam int RW = (FW + RAD_SHIFT + 1) / 2;
    localparam int VW = 2 * RW;
    localparam int MW = RW + 2;
    localparam int PW = SPEED_GAIN_W + RW;
    localparam int TW = PW + 1 - ROUND_SHIFT;

    logic [ROTORS-1:0][VW-1:0] r_rad  [RW];
    logic [ROTORS-1:0][MW-1:0] r_rem  [RW];
    logic [ROTORS-1:0][RW-1:0] r_root [RW];
    logic                      r_vld  [RW];
    logic                      r_lowp [RW];

    logic [ROTORS-1:0][VW-1:0] n_rad  [RW];
    logic [ROTORS-1:0][MW-1:0] n_rem  [RW];
    logic [ROTORS-1:0][RW-1:0] n_root [RW];

    logic [ROTORS-1:0][PW-1:0]         r_prod;
    logic                              r_m_vld;
    logic                              r_m_low;
    logic [ROTORS-1:0][DATA_WIDTH-1:0] r_speed;
    logic                              r_o_vld;
    logic                              r_o_low;
    logic                              r_o_high;

    logic [ROTORS-1:0][DATA_WIDTH-1:0] n_speed;
    logic [ROTORS-1:0]                 sat;
    logic                              en;

    // whole back pipeline holds while the output beat is stalled
    assign en      = !(r_o_vld && i_stall);
    assign o_ready = en;

    always_comb begin
        logic [VW-1:0] src_rad;
        logic [MW-1:0] src_rem;
        logic [RW-1:0] src_root;
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;
        for (int s = 0; s < RW; s++) begin
            for (int l = 0; l < ROTORS; l++) begin
                if (s == 0) begin
                    src_rad  = VW'({i_thrust[l], {RAD_SHIFT{1'b0}}});
                    src_rem  = '0;
                    src_root = '0;
                end else begin
                    src_rad  = r_rad[(s > 0) ? s - 1 : 0][l];
                    src_rem  = r_rem[(s > 0) ? s - 1 : 0][l];
                    src_root = r_root[(s > 0) ? s - 1 : 0][l];
                end
                rem_sh = {src_rem[MW-3:0], src_rad[VW-1 -: 2]};
                trial  = {src_root, 2'b01};
                n_rad[s][l] = {src_rad[VW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem[s][l]  = rem_sh - trial;
                    n_root[s][l] = {src_root[RW-2:0], 1'b1};
                end else begin
                    n_rem[s][l]  = rem_sh;
                    n_root[s][l] = {src_root[RW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [PW:0]   rounded;
        logic [TW-1:0] scaled;
        for (int l = 0; l < ROTORS; l++) begin
            rounded = (PW+1)'(r_prod[l]) + ((PW+1)'(1) << (ROUND_SHIFT - 1));
            scaled  = rounded[PW -: TW];
            sat[l]  = scaled > TW'({DATA_WIDTH{1'b1}});
            n_speed[l] = sat[l] ? {DATA_WIDTH{1'b1}} : scaled[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RW; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < RW; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_m_vld <= r_vld[RW-1];
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < RW; s++) begin
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
            r_lowp[0] <= i_low;
            for (int s = 1; s < RW; s++) begin
                r_lowp[s] <= r_lowp[s-1];
            end
            for (int l = 0; l < ROTORS; l++) begin
                r_prod[l] <= i_speed_gain * r_root[RW-1][l];
            end
            r_m_low  <= r_lowp[RW-1];
            r_speed  <= n_speed;
            r_o_low  <= r_m_low;
            r_o_high <= |sat;
        end
    end

    assign o_valid = r_o_vld;
    assign o_speed = r_speed;
    assign o_low   = r_o_low;
    assign o_high  = r_o_high;

endmodule

@@ sv/quad_plus_motor_mixer.sv @@
// top level of the plus-frame quadrotor motor mixer
//
//  channel   | valid        | flow control | payload
//  ----------+--------------+--------------+------------------------------------------
//  command   | i_in_valid   | o_in_stall   | i_total_thrust, i_roll_torque, i_pitch_torque
//  speeds    | o_out_valid  | i_out_stall  | o_front/left/back/right_speed, flags
//  config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one command per cycle sustained while the output is not stalled; the path runs through
//  1 front stage, the queue, (DATA_WIDTH+29)/2 square root stages (22 at 16 bits), 1 multiply and 1 output stage
//  the square root pipeline retires one bit of root per stage per rotor
//  synchronous active-low reset empties the queue and pipelines and reloads both gains
//  a stalled output beat freezes the back pipeline; the front stalls once the queue
//  plus the front stage hold four commands
module quad_plus_motor_mixer #(
    parameter int DATA_WIDTH = qpmm_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [DATA_WIDTH-1:0]              i_total_thrust,
    input  logic signed [DATA_WIDTH-1:0]       i_roll_torque,
    input  logic signed [DATA_WIDTH-1:0]       i_pitch_torque,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [DATA_WIDTH-1:0]              o_front_speed,
    output logic [DATA_WIDTH-1:0]              o_left_speed,
    output logic [DATA_WIDTH-1:0]              o_back_speed,
    output logic [DATA_WIDTH-1:0]              o_right_speed,
    output logic                               o_clamped_low,
    output logic                               o_saturated_high,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  qpmm_pkg::t_cfg_index               i_cfg_index,
    input  logic [qpmm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import qpmm_pkg::*;

    localparam int FW = DATA_WIDTH + 16;
    localparam int QW = ROTORS * FW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TORQUE_GAIN_W-1:0] r_torque_gain;
    logic [SPEED_GAIN_W-1:0]  r_speed_gain;

    logic                         push;
    logic [ROTORS-1:0][FW-1:0]    front_thrust;
    logic                         front_low;
    logic [CW-1:0]                q_count;
    logic                         q_valid;
    logic [QW-1:0]                q_data;
    logic                         back_ready;
    logic [ROTORS-1:0][FW-1:0]    back_thrust;
    logic [ROTORS-1:0][DATA_WIDTH-1:0] speed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_gain <= TORQUE_GAIN_RESET;
            r_speed_gain  <= SPEED_GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TORQUE_GAIN: begin
                    r_torque_gain <= i_cfg_data[TORQUE_GAIN_W-1:0];
                end
                CFG_SPEED_GAIN: begin
                    r_speed_gain <= i_cfg_data[SPEED_GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    qpmm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_total_thrust (i_total_thrust),
        .i_roll_torque  (i_roll_torque),
        .i_pitch_torque (i_pitch_torque),
        .i_torque_gain  (r_torque_gain),
        .i_queue_count  (q_count),
        .o_push         (push),
        .o_thrust       (front_thrust),
        .o_low          (front_low)
    );

    qpmm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_low, front_thrust}),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign back_thrust = q_data[QW-2:0];

    qpmm_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_ready      (back_ready),
        .i_thrust     (back_thrust),
        .i_low        (q_data[QW-1]),
        .i_speed_gain (r_speed_gain),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_speed      (speed),
        .o_low        (o_clamped_low),
        .o_high       (o_saturated_high)
    );

    assign o_front_speed = speed[LANE_FRONT];
    assign o_left_speed  = speed[LANE_LEFT];
    assign o_back_speed  = speed[LANE_BACK];
    assign o_right_speed = speed[LANE_RIGHT];

endmodule
